// File: hw/rtl/c6502_pkg.sv
package c6502_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
        OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
        OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
        OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
        OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
        OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
        OP_LSR = 6'd32, OP_ORA = 6'd33, OP_PHA = 6'd34, OP_PHP = 6'd35,
        OP_PLA = 6'd36, OP_PLP = 6'd37, OP_ROL = 6'd38, OP_NOP = 6'd39,
        OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
        OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
        OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
        OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
    } op_t;

    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    typedef struct packed {
        logic [5:0]        req_type;
        logic              accumulator_mode;
        logic [7:0]        operand;
        logic [15:0]       eff_addr;
        logic signed [7:0] branch_offset;
        logic [15:0]       next_pc;
        logic [7:0]        pull_byte1;
        logic [7:0]        pull_byte2;
        logic [7:0]        pull_byte3;
    } req_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        last;
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_ptr;
        logic [7:0]  status;
        logic [15:0] new_pc;
        logic [1:0]  extra_cycles;
    } rsp_t;

endpackage

// File: hw/rtl/c6502_front.sv
module c6502_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  c6502_pkg::req_t req,
    output logic            q_valid,
    input  logic            q_take,
    output c6502_pkg::req_t q_req
);
    import c6502_pkg::*;

    // two-entry request queue between accept and execute
    req_t       mem_reg [2];
    logic       wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign q_req   = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= req;
        end
    end
endmodule

// File: hw/rtl/c6502_back.sv
module c6502_back #(
    parameter logic [15:0] STACK_PAGE = 16'd256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_take,
    input  c6502_pkg::req_t q_req,
    input  logic [15:0]     irq_vector,
    output logic            out_valid,
    input  logic            out_take,
    output c6502_pkg::rsp_t rsp
);
    import c6502_pkg::*;

    logic [7:0] a_reg, x_reg, y_reg, sp_reg, p_reg;
    logic [7:0] a_next, x_next, y_next, sp_next, p_next;

    // pending writes of the instruction in flight
    rsp_t       base_reg;
    logic [1:0] nw_reg, idx_reg;
    logic [15:0] wa_reg [3];
    logic [7:0]  wd_reg [3];
    logic        busy_reg;

    logic [15:0] wa [3];
    logic [7:0]  wd [3];
    logic [1:0]  nw;
    logic [15:0] pc_n, tgt, pcv;
    logic [1:0]  extra;
    logic [8:0]  sum;
    logic [7:0]  m, v, r, opnd;
    logic        c, taken, is_branch, last_out, out_ok;

    always_comb
    begin
        m = q_req.operand;
        c = p_reg[FL_C];
        a_next = a_reg; x_next = x_reg; y_next = y_reg;
        sp_next = sp_reg; p_next = p_reg;
        pc_n = q_req.next_pc; extra = 2'd0; nw = 2'd0;
        wa[0] = 16'd0; wa[1] = 16'd0; wa[2] = 16'd0;
        wd[0] = 8'd0; wd[1] = 8'd0; wd[2] = 8'd0;
        sum = 9'd0; v = 8'd0; r = 8'd0; taken = 1'b0; is_branch = 1'b0;
        pcv = 16'd0;
        opnd = q_req.accumulator_mode ? a_reg : m;
        tgt = q_req.next_pc + {{8{q_req.branch_offset[7]}}, q_req.branch_offset};
        case (q_req.req_type)
            OP_ADC, OP_SBC:
            begin
                v = (q_req.req_type == OP_SBC) ? ~m : m;
                sum = {1'b0, a_reg} + {1'b0, v} + {8'd0, c};
                r = sum[7:0];
                p_next[FL_V] = (~(a_reg[7] ^ v[7])) & (a_reg[7] ^ r[7]);
                p_next[FL_C] = sum[8];
                a_next = r;
            end
            OP_AND: a_next = a_reg & m;
            OP_EOR: a_next = a_reg ^ m;
            OP_ORA: a_next = a_reg | m;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                case (q_req.req_type)
                    OP_ASL: r = {opnd[6:0], 1'b0};
                    OP_ROL: r = {opnd[6:0], c};
                    OP_LSR: r = {1'b0, opnd[7:1]};
                    default: r = {c, opnd[7:1]};
                endcase
                p_next[FL_C] = (q_req.req_type == OP_ASL || q_req.req_type == OP_ROL)
                               ? opnd[7] : opnd[0];
                p_next[FL_Z] = r == 8'd0;
                p_next[FL_N] = r[7];
                if (q_req.accumulator_mode)
                begin
                    a_next = r;
                end
                else
                begin
                    nw = 2'd1; wa[0] = q_req.eff_addr; wd[0] = r;
                end
            end
            OP_BCC: begin is_branch = 1'b1; taken = !p_reg[FL_C]; end
            OP_BCS: begin is_branch = 1'b1; taken = p_reg[FL_C]; end
            OP_BEQ: begin is_branch = 1'b1; taken = p_reg[FL_Z]; end
            OP_BMI: begin is_branch = 1'b1; taken = p_reg[FL_N]; end
            OP_BNE: begin is_branch = 1'b1; taken = !p_reg[FL_Z]; end
            OP_BPL: begin is_branch = 1'b1; taken = !p_reg[FL_N]; end
            OP_BVC: begin is_branch = 1'b1; taken = !p_reg[FL_V]; end
            OP_BVS: begin is_branch = 1'b1; taken = p_reg[FL_V]; end
            OP_BIT:
            begin
                p_next[FL_Z] = (a_reg & m) == 8'd0;
                p_next[FL_V] = m[6];
                p_next[FL_N] = m[7];
            end
            OP_BRK:
            begin
                pcv = q_req.next_pc + 16'd1;
                nw = 2'd3;
                wa[0] = STACK_PAGE + {8'd0, sp_reg};
                wa[1] = STACK_PAGE + {8'd0, sp_reg - 8'd1};
                wa[2] = STACK_PAGE + {8'd0, sp_reg - 8'd2};
                wd[0] = pcv[15:8]; wd[1] = pcv[7:0]; wd[2] = p_reg | 8'h10;
                sp_next = sp_reg - 8'd3;
                p_next[FL_I] = 1'b1;
                pc_n = irq_vector;
            end
            OP_CLC: p_next[FL_C] = 1'b0;
            OP_CLD: p_next[FL_D] = 1'b0;
            OP_CLI: p_next[FL_I] = 1'b0;
            OP_CLV: p_next[FL_V] = 1'b0;
            OP_SEC: p_next[FL_C] = 1'b1;
            OP_SED: p_next[FL_D] = 1'b1;
            OP_SEI: p_next[FL_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY:
            begin
                case (q_req.req_type)
                    OP_CMP: v = a_reg;
                    OP_CPX: v = x_reg;
                    default: v = y_reg;
                endcase
                sum = {1'b0, v} - {1'b0, m};
                p_next[FL_C] = !sum[8];
                p_next[FL_Z] = sum[7:0] == 8'd0;
                p_next[FL_N] = sum[7];
            end
            OP_DEC, OP_INC:
            begin
                r = (q_req.req_type == OP_DEC) ? m - 8'd1 : m + 8'd1;
                nw = 2'd1; wa[0] = q_req.eff_addr; wd[0] = r;
                p_next[FL_Z] = r == 8'd0;
                p_next[FL_N] = r[7];
            end
            OP_DEX: x_next = x_reg - 8'd1;
            OP_DEY: y_next = y_reg - 8'd1;
            OP_INX: x_next = x_reg + 8'd1;
            OP_INY: y_next = y_reg + 8'd1;
            OP_JMP: pc_n = q_req.eff_addr;
            OP_JSR:
            begin
                pcv = q_req.next_pc - 16'd1;
                nw = 2'd2;
                wa[0] = STACK_PAGE + {8'd0, sp_reg};
                wa[1] = STACK_PAGE + {8'd0, sp_reg - 8'd1};
                wd[0] = pcv[15:8]; wd[1] = pcv[7:0];
                sp_next = sp_reg - 8'd2;
                pc_n = q_req.eff_addr;
            end
            OP_LDA: a_next = m;
            OP_LDX: x_next = m;
            OP_LDY: y_next = m;
            OP_PHA, OP_PHP:
            begin
                nw = 2'd1;
                wa[0] = STACK_PAGE + {8'd0, sp_reg};
                wd[0] = (q_req.req_type == OP_PHA) ? a_reg : (p_reg | 8'h30);
                sp_next = sp_reg - 8'd1;
            end
            OP_PLA: begin sp_next = sp_reg + 8'd1; a_next = q_req.pull_byte1; end
            OP_PLP: begin sp_next = sp_reg + 8'd1; p_next = q_req.pull_byte1; end
            OP_RTI:
            begin
                sp_next = sp_reg + 8'd3;
                p_next = q_req.pull_byte1;
                pc_n = {q_req.pull_byte3, q_req.pull_byte2};
            end
            OP_RTS:
            begin
                sp_next = sp_reg + 8'd2;
                pc_n = {q_req.pull_byte2, q_req.pull_byte1} + 16'd1;
            end
            OP_STA: begin nw = 2'd1; wa[0] = q_req.eff_addr; wd[0] = a_reg; end
            OP_STX: begin nw = 2'd1; wa[0] = q_req.eff_addr; wd[0] = x_reg; end
            OP_STY: begin nw = 2'd1; wa[0] = q_req.eff_addr; wd[0] = y_reg; end
            OP_TAX: x_next = a_reg;
            OP_TAY: y_next = a_reg;
            OP_TSX: x_next = sp_reg;
            OP_TXA: a_next = x_reg;
            OP_TXS: sp_next = x_reg;
            OP_TYA: a_next = y_reg;
            default: ;
        endcase
        // nz for register results
        case (q_req.req_type)
            OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA, OP_LDA, OP_PLA, OP_TXA, OP_TYA:
            begin
                p_next[FL_Z] = a_next == 8'd0; p_next[FL_N] = a_next[7];
            end
            OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX:
            begin
                p_next[FL_Z] = x_next == 8'd0; p_next[FL_N] = x_next[7];
            end
            OP_DEY, OP_INY, OP_LDY, OP_TAY:
            begin
                p_next[FL_Z] = y_next == 8'd0; p_next[FL_N] = y_next[7];
            end
            default: ;
        endcase
        if (is_branch && taken)
        begin
            pc_n  = tgt;
            extra = (tgt[15:8] != q_req.next_pc[15:8]) ? 2'd2 : 2'd1;
        end
    end

    // output register holds one result; next result loads when it drains
    assign out_valid = busy_reg;
    assign last_out  = (nw_reg == 2'd0) || (idx_reg == nw_reg - 2'd1);
    assign out_ok    = !busy_reg || (out_take && last_out);
    assign q_take    = out_ok;

    always_comb
    begin
        rsp = base_reg;
        rsp.last = last_out;
        if (nw_reg != 2'd0)
        begin
            rsp.write_enable = 1'b1;
            rsp.write_addr   = wa_reg[idx_reg];
            rsp.write_data   = wd_reg[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'd0; x_reg <= 8'd0; y_reg <= 8'd0;
            sp_reg <= SP_RESET; p_reg <= STATUS_RESET;
            busy_reg <= 1'b0; idx_reg <= 2'd0; nw_reg <= 2'd0;
        end
        else if (q_valid && out_ok)
        begin
            a_reg <= a_next; x_reg <= x_next; y_reg <= y_next;
            sp_reg <= sp_next; p_reg <= p_next;
            busy_reg <= 1'b1; idx_reg <= 2'd0; nw_reg <= nw;
        end
        else if (busy_reg && out_take)
        begin
            if (last_out)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && out_ok)
        begin
            base_reg <= '{write_enable: 1'b0, write_addr: 16'd0, write_data: 8'd0,
                          last: 1'b0, acc: a_next, index_x: x_next, index_y: y_next,
                          stack_ptr: sp_next, status: p_next, new_pc: pc_n,
                          extra_cycles: extra};
            wa_reg <= wa;
            wd_reg <= wd;
        end
    end
endmodule

// File: hw/rtl/cpu6502_instruction_execute.sv
// a request's first result reaches the result ports after it passes the request queue and the result register
// throughput: one request per cycle for single-result instructions while results are popped;
// instructions that write memory occupy the result register for one result per write (up to 3)
// a two-entry request queue decouples accept from the execute unit
// reset: A=X=Y=0, SP=0xFD, P=0x24, irq_vector=0, queues empty
module cpu6502_instruction_execute #(
    parameter logic [15:0] STACK_PAGE = 16'd256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  c6502_pkg::req_t req,
    output logic            empty,
    input  logic            pop,
    output c6502_pkg::rsp_t rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [15:0]     cfg_data
);
    import c6502_pkg::*;

    logic        q_valid, q_take, out_valid;
    req_t        q_req;
    logic [15:0] irq_vector_reg;

    assign cfg_ready = 1'b1;
    assign empty     = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_vector_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            irq_vector_reg <= cfg_data;
        end
    end

    c6502_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
    );

    c6502_back #(.STACK_PAGE(STACK_PAGE)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_req(q_req), .irq_vector(irq_vector_reg), .out_valid(out_valid),
        .out_take(pop), .rsp(rsp)
    );

    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rsp.write_enable |-> rsp.write_addr == 16'd0 && rsp.last)
        else $error("result without write not clean");
    a_extra_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.extra_cycles != 2'd0 |-> !rsp.write_enable)
        else $error("branch penalty with write");
    a_multi_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !rsp.last |=> !empty && $stable(rsp.new_pc))
        else $error("multi-write instruction broke up");
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import c6502_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_COUNT = 96;
    localparam int CALM_TAIL = 12;
    localparam int NUM_CODES = 57;
    localparam logic [15:0] STK_PAGE_ADDR = 16'd256;
    localparam logic [5:0] OP_UNDEF = 6'd56;
    localparam logic [5:0] OP_TOP = 6'd63;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;

    cpu6502_instruction_execute dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .empty(empty),
        .pop(pop),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // cpu state as the block should hold it
    logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
    logic [15:0] cpu_vector;

    rsp_t expected_rsp[$];
    int errors;
    int idle_cycles;
    bit calm;
    int pop_gap;

    initial begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic void set_nz(input logic [7:0] v);
        cpu_p[FL_Z] = (v == 8'h00);
        cpu_p[FL_N] = v[7];
    endfunction

    function automatic void do_compare(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] d;
        d = r - m;
        cpu_p[FL_C] = (r >= m);
        cpu_p[FL_Z] = (r == m);
        cpu_p[FL_N] = d[7];
    endfunction

    // runs one instruction on the shadow cpu and queues its results
    function automatic void execute_instr(input req_t q);
        logic [15:0] wa[3];
        logic [7:0] wd[3];
        int nw;
        int n;
        logic [15:0] pc;
        logic [15:0] tgt;
        logic [15:0] t16;
        logic [8:0] sum;
        logic [7:0] v;
        logic [7:0] r;
        logic c;
        logic take;
        logic is_branch;
        logic [1:0] extra;
        rsp_t o;
        nw = 0;
        pc = q.next_pc;
        extra = 2'd0;
        c = cpu_p[FL_C];
        take = 1'b0;
        is_branch = 1'b1;
        case (q.req_type)
            OP_BCC: take = !cpu_p[FL_C];
            OP_BCS: take = cpu_p[FL_C];
            OP_BEQ: take = cpu_p[FL_Z];
            OP_BMI: take = cpu_p[FL_N];
            OP_BNE: take = !cpu_p[FL_Z];
            OP_BPL: take = !cpu_p[FL_N];
            OP_BVC: take = !cpu_p[FL_V];
            OP_BVS: take = cpu_p[FL_V];
            default: is_branch = 1'b0;
        endcase
        if (is_branch && take) begin
            tgt = pc + {{8{q.branch_offset[7]}}, q.branch_offset};
            extra = (tgt[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
            pc = tgt;
        end
        case (q.req_type)
            OP_ADC, OP_SBC: begin
                v = (q.req_type == OP_SBC) ? ~q.operand : q.operand;
                sum = {1'b0, cpu_a} + {1'b0, v} + {8'd0, c};
                cpu_p[FL_V] = ~(cpu_a[7] ^ v[7]) & (cpu_a[7] ^ sum[7]);
                cpu_p[FL_C] = sum[8];
                cpu_a = sum[7:0];
                set_nz(cpu_a);
            end
            OP_AND: begin cpu_a = cpu_a & q.operand; set_nz(cpu_a); end
            OP_EOR: begin cpu_a = cpu_a ^ q.operand; set_nz(cpu_a); end
            OP_ORA: begin cpu_a = cpu_a | q.operand; set_nz(cpu_a); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                v = q.accumulator_mode ? cpu_a : q.operand;
                case (q.req_type)
                    OP_ASL: r = {v[6:0], 1'b0};
                    OP_LSR: r = {1'b0, v[7:1]};
                    OP_ROL: r = {v[6:0], c};
                    default: r = {c, v[7:1]};
                endcase
                cpu_p[FL_C] = (q.req_type == OP_ASL || q.req_type == OP_ROL) ? v[7] : v[0];
                set_nz(r);
                if (q.accumulator_mode) begin
                    cpu_a = r;
                end
                else begin
                    wa[nw] = q.eff_addr; wd[nw] = r; nw++;
                end
            end
            OP_BIT: begin
                cpu_p[FL_Z] = ((cpu_a & q.operand) == 8'h00);
                cpu_p[FL_V] = q.operand[6];
                cpu_p[FL_N] = q.operand[7];
            end
            OP_BRK: begin
                t16 = q.next_pc + 16'd1;
                wa[0] = STK_PAGE_ADDR + cpu_sp; wd[0] = t16[15:8];
                wa[1] = STK_PAGE_ADDR + 8'(cpu_sp - 8'd1); wd[1] = t16[7:0];
                wa[2] = STK_PAGE_ADDR + 8'(cpu_sp - 8'd2); wd[2] = cpu_p | 8'h10;
                nw = 3;
                cpu_sp = cpu_sp - 8'd3;
                cpu_p[FL_I] = 1'b1;
                pc = cpu_vector;
            end
            OP_CLC: cpu_p[FL_C] = 1'b0;
            OP_CLD: cpu_p[FL_D] = 1'b0;
            OP_CLI: cpu_p[FL_I] = 1'b0;
            OP_CLV: cpu_p[FL_V] = 1'b0;
            OP_SEC: cpu_p[FL_C] = 1'b1;
            OP_SED: cpu_p[FL_D] = 1'b1;
            OP_SEI: cpu_p[FL_I] = 1'b1;
            OP_CMP: do_compare(cpu_a, q.operand);
            OP_CPX: do_compare(cpu_x, q.operand);
            OP_CPY: do_compare(cpu_y, q.operand);
            OP_DEC, OP_INC: begin
                r = (q.req_type == OP_DEC) ? q.operand - 8'd1 : q.operand + 8'd1;
                wa[0] = q.eff_addr; wd[0] = r; nw = 1;
                set_nz(r);
            end
            OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
            OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
            OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
            OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
            OP_JMP: pc = q.eff_addr;
            OP_JSR: begin
                t16 = q.next_pc - 16'd1;
                wa[0] = STK_PAGE_ADDR + cpu_sp; wd[0] = t16[15:8];
                wa[1] = STK_PAGE_ADDR + 8'(cpu_sp - 8'd1); wd[1] = t16[7:0];
                nw = 2;
                cpu_sp = cpu_sp - 8'd2;
                pc = q.eff_addr;
            end
            OP_LDA: begin cpu_a = q.operand; set_nz(cpu_a); end
            OP_LDX: begin cpu_x = q.operand; set_nz(cpu_x); end
            OP_LDY: begin cpu_y = q.operand; set_nz(cpu_y); end
            OP_PHA: begin
                wa[0] = STK_PAGE_ADDR + cpu_sp; wd[0] = cpu_a; nw = 1;
                cpu_sp = cpu_sp - 8'd1;
            end
            OP_PHP: begin
                wa[0] = STK_PAGE_ADDR + cpu_sp; wd[0] = cpu_p | 8'h30; nw = 1;
                cpu_sp = cpu_sp - 8'd1;
            end
            OP_PLA: begin cpu_sp = cpu_sp + 8'd1; cpu_a = q.pull_byte1; set_nz(cpu_a); end
            OP_PLP: begin cpu_sp = cpu_sp + 8'd1; cpu_p = q.pull_byte1; end
            OP_RTI: begin
                cpu_sp = cpu_sp + 8'd3;
                cpu_p = q.pull_byte1;
                pc = {q.pull_byte3, q.pull_byte2};
            end
            OP_RTS: begin
                cpu_sp = cpu_sp + 8'd2;
                pc = {q.pull_byte2, q.pull_byte1} + 16'd1;
            end
            OP_STA: begin wa[0] = q.eff_addr; wd[0] = cpu_a; nw = 1; end
            OP_STX: begin wa[0] = q.eff_addr; wd[0] = cpu_x; nw = 1; end
            OP_STY: begin wa[0] = q.eff_addr; wd[0] = cpu_y; nw = 1; end
            OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
            OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
            OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
            OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
            OP_TXS: cpu_sp = cpu_x;
            OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
            default: ;
        endcase
        n = (nw > 0) ? nw : 1;
        for (int k = 0; k < n; k++) begin
            o = '0;
            if (k < nw) begin
                o.write_enable = 1'b1;
                o.write_addr = wa[k];
                o.write_data = wd[k];
            end
            o.last = (k == n - 1);
            o.acc = cpu_a;
            o.index_x = cpu_x;
            o.index_y = cpu_y;
            o.stack_ptr = cpu_sp;
            o.status = cpu_p;
            o.new_pc = pc;
            o.extra_cycles = extra;
            expected_rsp.push_back(o);
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_rsp(input rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0) begin
            $error("unexpected result: %p", got);
            errors++;
        end
        else begin
            want = expected_rsp.pop_front();
            check_field("write_enable", want.write_enable, got.write_enable);
            check_field("write_addr", want.write_addr, got.write_addr);
            check_field("write_data", want.write_data, got.write_data);
            check_field("last", want.last, got.last);
            check_field("acc", want.acc, got.acc);
            check_field("index_x", want.index_x, got.index_x);
            check_field("index_y", want.index_y, got.index_y);
            check_field("stack_ptr", want.stack_ptr, got.stack_ptr);
            check_field("status", want.status, got.status);
            check_field("new_pc", want.new_pc, got.new_pc);
            check_field("extra_cycles", want.extra_cycles, got.extra_cycles);
        end
    endtask

    // result side: sample at rising edge, change pop at falling edge
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            check_rsp(rsp);
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
            pop_gap = 0;
        end
        else if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0) begin
            pop_gap = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end
        else begin
            pop <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted handshake
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_instr(input req_t q, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= q;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        execute_instr(q);
        @(negedge clk);
    endtask

    task automatic write_vector(input logic [15:0] value);
        int guard;
        push <= 1'b0;
        guard = 0;
        while (expected_rsp.size() != 0 && guard < 100000) begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cpu_vector = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t make_instr(input logic [5:0] code, input logic [7:0] m);
        req_t q;
        q.req_type = code;
        q.accumulator_mode = 1'($urandom_range(0, 1));
        q.operand = m;
        q.eff_addr = 16'($urandom);
        q.branch_offset = 8'($urandom);
        q.next_pc = 16'($urandom);
        q.pull_byte1 = 8'($urandom);
        q.pull_byte2 = 8'($urandom);
        q.pull_byte3 = 8'($urandom);
        return q;
    endfunction

    // directed rows: code, operand, accumulator mode, address, offset, pc
    typedef struct {
        logic [5:0] code;
        logic [7:0] m;
        logic accm;
        logic [15:0] ea;
        logic [7:0] off;
        logic [15:0] pc;
    } row_t;

    row_t table_rows[] = '{
        '{OP_NOP, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_LDA, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'hFFFF},
        '{OP_ADC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_LDA, 8'h7F, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_ADC, 8'h01, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_SBC, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_SED, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_ADC, 8'h99, 1'b0, 16'h0000, 8'h00, 16'h1234},
        '{OP_BRK, 8'h00, 1'b0, 16'h0000, 8'h00, 16'hFFFF},
        '{OP_PHP, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0100},
        '{OP_JSR, 8'h00, 1'b0, 16'hFFFF, 8'h00, 16'h0000},
        '{OP_TXS, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_PHA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_PLA, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_RTS, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_RTI, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h0000},
        '{OP_BNE, 8'h00, 1'b0, 16'h0000, 8'h80, 16'h0000},
        '{OP_BEQ, 8'h00, 1'b0, 16'h0000, 8'h7F, 16'hFFF0},
        '{OP_ROL, 8'h80, 1'b1, 16'h0000, 8'h00, 16'h2000},
        '{OP_ROR, 8'h01, 1'b0, 16'hABCD, 8'h00, 16'h2000},
        '{OP_CMP, 8'hFF, 1'b0, 16'h0000, 8'h00, 16'h2000},
        '{OP_UNDEF, 8'h00, 1'b0, 16'h0000, 8'h00, 16'h4321},
        '{OP_TOP, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 16'h8765}
    };

    // weighted pick: favors valid opcodes, some undefined
    function automatic logic [5:0] pick_code();
        if ($urandom_range(0, 19) == 0) begin
            return 6'($urandom_range(NUM_CODES - 1, 63));
        end
        return 6'($urandom_range(0, NUM_CODES - 2));
    endfunction

    initial begin
        req_t q;
        logic [15:0] vectors[4];
        errors = 0;
        calm = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = 16'h0000;
        cpu_a = 8'h00;
        cpu_x = 8'h00;
        cpu_y = 8'h00;
        cpu_sp = SP_RESET;
        cpu_p = STATUS_RESET;
        cpu_vector = 16'h0000;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset nothing was written: BRK loads a zero vector
        foreach (table_rows[i]) begin
            q = make_instr(table_rows[i].code, table_rows[i].m);
            q.accumulator_mode = table_rows[i].accm;
            q.eff_addr = table_rows[i].ea;
            q.branch_offset = table_rows[i].off;
            q.next_pc = table_rows[i].pc;
            if (i == 0) begin
                q.pull_byte1 = 8'h00;
                q.pull_byte2 = 8'hFF;
                q.pull_byte3 = 8'hFF;
            end
            send_instr(q, 1'b0);
            if (i == 0) begin
                // reset state, read off directly
                if (expected_rsp[0] !== rsp_t'{1'b0, 16'h0000, 8'h00, 1'b1, 8'h00,
                        8'h00, 8'h00, SP_RESET, STATUS_RESET, 16'h0000, 2'd0}) begin
                    $error("predictor disagrees on reset state");
                    errors++;
                end
            end
        end

        vectors = '{16'hFFFF, 16'h0000, 16'h8000, 16'($urandom)};
        for (int phase = 0; phase < 4; phase++) begin
            write_vector(vectors[phase]);
            q = make_instr(OP_BRK, 8'h00);
            send_instr(q, 1'b1);
            for (int i = 0; i < RANDOM_COUNT / 4; i++) begin
                if (phase == 3 && i >= RANDOM_COUNT / 4 - CALM_TAIL) begin
                    calm = 1'b1;
                end
                q = make_instr(pick_code(), 8'($urandom));
                send_instr(q, !calm);
            end
        end
        push <= 1'b0;

        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
